// ----- hdl/tst_pkg.sv -----
// Shared constants, types and the power-on stop pattern for the tab stop table.
package tst_pkg;

  localparam int MAX_COLUMNS = 256;
  localparam int TAB_SPACING = 8;
  localparam int COUNT_RESET = 80;

  localparam int MODE_W  = 3;
  localparam int COL_W   = 9;
  localparam int OUT_W   = 8;
  localparam int COUNT_W = 9;

  // Table is kept as words of DIGIT_W columns, scanned one word at a time
  localparam int DIGIT_W   = 8;
  localparam int DIGIT_LOG = $clog2(DIGIT_W);
  localparam int NUM_WORDS = MAX_COLUMNS / DIGIT_W;
  localparam int WADDR_W   = $clog2(NUM_WORDS);
  localparam int POS_W     = WADDR_W + DIGIT_LOG;
  localparam int NCNT_W    = $clog2(MAX_COLUMNS + 1);
  localparam int BND_W     = ((NCNT_W > COL_W) ? NCNT_W : COL_W) + 1;

  localparam int IN_W       = MODE_W + COL_W;
  localparam int IN_TDATA_W = ((IN_W + 7) / 8) * 8;
  localparam int OUT_TDATA_W = ((OUT_W + 7) / 8) * 8;

  typedef logic [DIGIT_W-1:0] digit_t;

  typedef enum logic [MODE_W-1:0] {
    MODE_RESET = 3'd0,
    MODE_SET   = 3'd1,
    MODE_CLEAR = 3'd2,
    MODE_NEXT  = 3'd3,
    MODE_PREV  = 3'd4
  } mode_t;

  // Power-on stop pattern of one table word
  function automatic digit_t pattern_word(input logic [WADDR_W-1:0] w);
    digit_t d;
    logic [POS_W-1:0] p;
    d = '0;
    for (int b = 0; b < DIGIT_W; b++) begin
      p = {w, DIGIT_LOG'(b)};
      d[b] = ((p % TAB_SPACING) == 0);
    end
    return d;
  endfunction

endpackage

// ----- hdl/tab_stop_table_core.sv -----
// Tab stop table: per-column stop bits with set, clear, reset and word-serial searches.
// Search path: each 8-column word scanned passes ST_READ then ST_CHECK; the result goes via
//   ST_RESULT into the output register; an edge default goes from idle straight to ST_RESULT.
// Throughput: one item at a time; set and clear in range pass ST_READ and ST_UPDATE, all other
//   non-search items stay in idle; a held result stalls input.
// Reset: rst clears control, loads column_count 80 and restores the power-on stop pattern
//   at once through per-word valid bits; the reset-all operation restores the pattern likewise.
module tab_stop_table_core (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               s_tvalid,
  output logic                               s_tready,
  input  logic [tst_pkg::IN_TDATA_W-1:0]     s_tdata,   // [2:0] mode, [11:3] col
  output logic                               m_tvalid,
  input  logic                               m_tready,
  output logic [tst_pkg::OUT_TDATA_W-1:0]    m_tdata,   // [7:0] stop_col
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [tst_pkg::COUNT_W-1:0]        cfg_data   // [8:0] column_count
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_READ,
    ST_CHECK,
    ST_UPDATE,
    ST_RESULT
  } state_t;

  state_t                          state;
  tst_pkg::mode_t                  op;
  logic [tst_pkg::BND_W-1:0]       lb;
  logic [tst_pkg::BND_W-1:0]       ub;
  logic [tst_pkg::WADDR_W-1:0]     word;
  logic [tst_pkg::WADDR_W-1:0]     end_word;
  logic [tst_pkg::DIGIT_LOG-1:0]   bit_sel;
  logic [tst_pkg::NUM_WORDS-1:0]   wvalid;
  tst_pkg::digit_t                 mem [tst_pkg::NUM_WORDS];
  tst_pkg::digit_t                 rdata;
  logic                            rvalid;
  logic [tst_pkg::OUT_W-1:0]       res;
  logic [tst_pkg::OUT_W-1:0]       out_data;
  logic                            out_valid;
  logic [tst_pkg::NCNT_W-1:0]      ncols;

  tst_pkg::mode_t                  in_mode;
  logic [tst_pkg::COL_W-1:0]       in_col;
  logic [tst_pkg::BND_W-1:0]       col_ext;
  logic [tst_pkg::BND_W-1:0]       n_ext;
  logic [tst_pkg::BND_W-1:0]       nx_lb;
  logic [tst_pkg::BND_W-1:0]       pv_ub;
  logic [tst_pkg::BND_W-1:0]       pv_last;
  logic [tst_pkg::BND_W-1:0]       last_col;
  logic [tst_pkg::BND_W-1:0]       cfg_ext;
  logic [tst_pkg::NCNT_W-1:0]      cfg_sat;
  tst_pkg::digit_t                 cur;
  tst_pkg::digit_t                 hit;
  tst_pkg::digit_t                 upd_word;
  logic [tst_pkg::DIGIT_LOG-1:0]   lo_idx;
  logic [tst_pkg::DIGIT_LOG-1:0]   hi_idx;
  logic [tst_pkg::POS_W-1:0]       found_pos;
  logic [tst_pkg::BND_W-1:0]       pos;

  // Unpack the input transaction and form search bounds
  assign in_mode  = tst_pkg::mode_t'(s_tdata[tst_pkg::MODE_W-1:0]);
  assign in_col   = s_tdata[tst_pkg::MODE_W+tst_pkg::COL_W-1:tst_pkg::MODE_W];
  assign col_ext  = tst_pkg::BND_W'(in_col);
  assign n_ext    = tst_pkg::BND_W'(ncols);
  assign nx_lb    = col_ext + tst_pkg::BND_W'(1);
  assign pv_ub    = (col_ext < n_ext) ? col_ext : n_ext;
  assign pv_last  = pv_ub - tst_pkg::BND_W'(1);
  assign last_col = n_ext - tst_pkg::BND_W'(1);

  // Saturate the column count to 1..MAX_COLUMNS
  assign cfg_ext = tst_pkg::BND_W'(cfg_data);
  always_comb begin
    if (cfg_ext == '0) begin
      cfg_sat = tst_pkg::NCNT_W'(1);
    end else if (cfg_ext > tst_pkg::BND_W'(tst_pkg::MAX_COLUMNS)) begin
      cfg_sat = tst_pkg::NCNT_W'(tst_pkg::MAX_COLUMNS);
    end else begin
      cfg_sat = tst_pkg::NCNT_W'(cfg_ext);
    end
  end

  // Current word: stored value once written, else the power-on pattern
  assign cur = rvalid ? rdata : tst_pkg::pattern_word(word);

  // Mark stops inside [lb, ub) and pick the lowest and highest
  always_comb begin
    hit    = '0;
    lo_idx = '0;
    hi_idx = '0;
    pos    = '0;
    for (int b = 0; b < tst_pkg::DIGIT_W; b++) begin
      pos    = tst_pkg::BND_W'({word, tst_pkg::DIGIT_LOG'(b)});
      hit[b] = cur[b] && (pos >= lb) && (pos < ub);
    end
    for (int b = tst_pkg::DIGIT_W - 1; b >= 0; b--) begin
      if (hit[b]) lo_idx = tst_pkg::DIGIT_LOG'(b);
    end
    for (int b = 0; b < tst_pkg::DIGIT_W; b++) begin
      if (hit[b]) hi_idx = tst_pkg::DIGIT_LOG'(b);
    end
  end

  assign found_pos = {word, (op == tst_pkg::MODE_NEXT) ? lo_idx : hi_idx};

  // Read-modify-write value for set and clear
  always_comb begin
    upd_word          = cur;
    upd_word[bit_sel] = (op == tst_pkg::MODE_SET);
  end

  // Table memory: one word written or read per cycle
  always_ff @(posedge clk) begin
    if (state == ST_UPDATE) begin
      mem[word] <= upd_word;
    end
    if (state == ST_READ) begin
      rdata  <= mem[word];
      rvalid <= wvalid[word];
    end
  end

  // Sequencer, configuration register and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      wvalid    <= '0;
      out_valid <= 1'b0;
      ncols     <= tst_pkg::NCNT_W'(tst_pkg::COUNT_RESET);
    end else begin
      if (cfg_valid) begin
        ncols <= cfg_sat;
      end
      // Load a finished search into the output register, else drop a taken result
      if (state == ST_RESULT && (!out_valid || m_tready)) begin
        out_valid <= 1'b1;
        out_data  <= res;
      end else if (m_tready) begin
        out_valid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (s_tvalid) begin
            op <= in_mode;
            case (in_mode)
              tst_pkg::MODE_RESET: begin
                wvalid <= '0;
              end
              tst_pkg::MODE_SET, tst_pkg::MODE_CLEAR: begin
                if (col_ext < n_ext) begin
                  word    <= in_col[tst_pkg::POS_W-1:tst_pkg::DIGIT_LOG];
                  bit_sel <= in_col[tst_pkg::DIGIT_LOG-1:0];
                  state   <= ST_READ;
                end
              end
              tst_pkg::MODE_NEXT: begin
                lb <= nx_lb;
                ub <= n_ext;
                if (nx_lb >= n_ext) begin
                  res   <= tst_pkg::OUT_W'(last_col);
                  state <= ST_RESULT;
                end else begin
                  word     <= nx_lb[tst_pkg::POS_W-1:tst_pkg::DIGIT_LOG];
                  end_word <= last_col[tst_pkg::POS_W-1:tst_pkg::DIGIT_LOG];
                  state    <= ST_READ;
                end
              end
              tst_pkg::MODE_PREV: begin
                lb <= '0;
                ub <= pv_ub;
                if (pv_ub == '0) begin
                  res   <= '0;
                  state <= ST_RESULT;
                end else begin
                  word     <= pv_last[tst_pkg::POS_W-1:tst_pkg::DIGIT_LOG];
                  end_word <= '0;
                  state    <= ST_READ;
                end
              end
              default: begin
              end
            endcase
          end
        end
        ST_READ: begin
          if (op inside {tst_pkg::MODE_SET, tst_pkg::MODE_CLEAR}) begin
            state <= ST_UPDATE;
          end else begin
            state <= ST_CHECK;
          end
        end
        ST_CHECK: begin
          if (|hit) begin
            res   <= tst_pkg::OUT_W'(found_pos);
            state <= ST_RESULT;
          end else if (word == end_word) begin
            res   <= (op == tst_pkg::MODE_NEXT) ? tst_pkg::OUT_W'(ub - tst_pkg::BND_W'(1)) : '0;
            state <= ST_RESULT;
          end else begin
            word  <= (op == tst_pkg::MODE_NEXT) ? word + tst_pkg::WADDR_W'(1)
                                                : word - tst_pkg::WADDR_W'(1);
            state <= ST_READ;
          end
        end
        ST_UPDATE: begin
          wvalid[word] <= 1'b1;
          state        <= ST_IDLE;
        end
        ST_RESULT: begin
          if (!out_valid || m_tready) begin
            state <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  assign s_tready  = (state == ST_IDLE);
  assign cfg_ready = 1'b1;
  assign m_tvalid  = out_valid;
  assign m_tdata   = tst_pkg::OUT_TDATA_W'(out_data);

`ifndef SYNTHESIS
  // Effective column count stays in range
  a_ncols_range: assert property (@(posedge clk) disable iff (rst)
    (ncols != '0) && (ncols <= tst_pkg::NCNT_W'(tst_pkg::MAX_COLUMNS)))
    else $error("column count out of range");

  // Forward scan never passes its last word
  a_next_bound: assert property (@(posedge clk) disable iff (rst)
    (state == ST_CHECK && op == tst_pkg::MODE_NEXT) |-> (word <= end_word))
    else $error("forward scan past last word");

  // An accepted search leaves idle
  a_search_busy: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready && (in_mode == tst_pkg::MODE_NEXT || in_mode == tst_pkg::MODE_PREV))
    |=> (state != ST_IDLE))
    else $error("search accepted but sequencer stayed idle");

  // A finished search with a free output slot presents its result
  a_result_out: assert property (@(posedge clk) disable iff (rst)
    (state == ST_RESULT && (!out_valid || m_tready))
    |=> (m_tvalid && m_tdata[tst_pkg::OUT_W-1:0] == $past(res)))
    else $error("search result not presented");
`endif

endmodule

// ----- sim/testbench.sv -----
`timescale 1ns / 1ps
// Self-checking testbench for tab_stop_table_core: random and directed tab-stop commands.
module testbench;

  localparam int MAX_GAP       = 16;
  localparam int SETTLE_CYCLES = 2 * tst_pkg::NUM_WORDS + 8;
  localparam int LONG_HOLD     = 400;
  localparam int PHASE_ITEMS   = 160;
  localparam int REPORT_LIMIT  = 10;

  // Column predictor: mirrors the stop bitmap and queues expected search answers
  class stop_table_model;
    bit [tst_pkg::MAX_COLUMNS-1:0] stops;
    bit [tst_pkg::COUNT_W-1:0]     count;
    bit [tst_pkg::OUT_W-1:0]       expected_cols[$];
    int                            mismatches;

    function new();
      count      = tst_pkg::COUNT_RESET;
      mismatches = 0;
      load_pattern();
    endfunction

    function void load_pattern();
      for (int i = 0; i < tst_pkg::MAX_COLUMNS; i++)
        stops[i] = ((i % tst_pkg::TAB_SPACING) == 0);
    endfunction

    // Saturate the programmed count to the legal column range
    function int columns_in_use();
      if (count < 1) return 1;
      if (count > tst_pkg::MAX_COLUMNS) return tst_pkg::MAX_COLUMNS;
      return count;
    endfunction

    function void accept_command(input logic [tst_pkg::MODE_W-1:0] m,
                                 input logic [tst_pkg::COL_W-1:0] c);
      int n;
      int pos;
      bit hit;
      n   = columns_in_use();
      pos = 0;
      hit = 1'b0;
      case (m)
        tst_pkg::MODE_RESET: load_pattern();
        tst_pkg::MODE_SET:   if (c < n) stops[c] = 1'b1;
        tst_pkg::MODE_CLEAR: if (c < n) stops[c] = 1'b0;
        tst_pkg::MODE_NEXT: begin
          // Fall back to the last column in use when no stop lies ahead
          pos = n - 1;
          for (int i = int'(c) + 1; i < n && !hit; i++) begin
            if (stops[i]) begin
              pos = i;
              hit = 1'b1;
            end
          end
          expected_cols.push_back(tst_pkg::OUT_W'(pos));
        end
        tst_pkg::MODE_PREV: begin
          // Start below the column, clipped to the count; column 0 when nothing found
          for (int i = ((c < n) ? int'(c) : n) - 1; i >= 0 && !hit; i--) begin
            if (stops[i]) begin
              pos = i;
              hit = 1'b1;
            end
          end
          expected_cols.push_back(tst_pkg::OUT_W'(pos));
        end
        default: ;
      endcase
    endfunction

    function void check_stop_col(input logic [tst_pkg::OUT_W-1:0] got);
      bit [tst_pkg::OUT_W-1:0] want;
      if (expected_cols.size() == 0) begin
        mismatches++;
        if (mismatches <= REPORT_LIMIT)
          $display("%0t: unexpected stop_col result %0d", $time, got);
        return;
      end
      want = expected_cols.pop_front();
      if (got !== want) begin
        mismatches++;
        if (mismatches <= REPORT_LIMIT)
          $display("%0t: stop_col mismatch, expected %0d, actual %0d", $time, want, got);
      end
    endfunction
  endclass

  logic                            clk;
  logic                            rst;
  logic                            s_tvalid;
  logic                            s_tready;
  logic [tst_pkg::IN_TDATA_W-1:0]  s_tdata;
  logic                            m_tvalid;
  logic                            m_tready;
  logic [tst_pkg::OUT_TDATA_W-1:0] m_tdata;
  logic                            cfg_valid;
  logic                            cfg_ready;
  logic [tst_pkg::COUNT_W-1:0]     cfg_data;

  stop_table_model tbl;
  bit              src_idle;
  bit              snk_idle;
  int              hold_cycles;

  tab_stop_table_core u_dut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  // Generate the 10 ns clock
  initial clk = 1'b0;
  always #5 clk = ~clk;

  // Abort a hung run
  initial begin
    #5_000_000;
    $display("** tab_stop_table_core: FAILED **");
    $finish;
  end

  // Accept results with random stalls; honor a long hold-off when one is requested
  initial begin
    int gap;
    m_tready = 1'b0;
    wait (rst == 1'b0);
    forever begin
      gap = snk_idle ? $urandom_range(0, MAX_GAP) : 0;
      if (hold_cycles > 0) begin
        gap         = hold_cycles;
        hold_cycles = 0;
      end
      if (gap > 0) begin
        @(negedge clk);
        m_tready <= 1'b0;
        repeat (gap - 1) @(negedge clk);
      end
      @(negedge clk);
      m_tready <= 1'b1;
      do @(posedge clk); while (!m_tvalid);
      tbl.check_stop_col(m_tdata[tst_pkg::OUT_W-1:0]);
    end
  end

  // Offer one command after a random gap and hold it until the transaction completes
  task automatic send_command(input logic [tst_pkg::MODE_W-1:0] m,
                              input logic [tst_pkg::COL_W-1:0] c);
    int gap;
    gap = src_idle ? $urandom_range(0, MAX_GAP) : 0;
    if (gap > 0) begin
      @(negedge clk);
      s_tvalid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    s_tvalid <= 1'b1;
    s_tdata  <= tst_pkg::IN_TDATA_W'({c, m});
    do @(posedge clk); while (!s_tready);
    tbl.accept_command(m, c);
  endtask

  // Drain all pending answers and let any set or clear finish
  task automatic settle();
    @(negedge clk);
    s_tvalid <= 1'b0;
    while (tbl.expected_cols.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_column_count(input logic [tst_pkg::COUNT_W-1:0] v);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= v;
    do @(posedge clk); while (!cfg_ready);
    tbl.count = v;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // Program a count, then run mostly in-range edits and searches with some noise
  task automatic run_phase(input int count_val, input int items, input bit restart);
    int n;
    int done;
    int pick;
    int m;
    int c;
    settle();
    write_column_count(count_val[tst_pkg::COUNT_W-1:0]);
    n = tbl.columns_in_use();
    if (restart)
      send_command(tst_pkg::MODE_RESET,
                   tst_pkg::COL_W'($urandom_range(0, (1 << tst_pkg::COL_W) - 1)));
    done = 0;
    while (done < items) begin
      pick = $urandom_range(0, 99);
      if (pick < 3) m = tst_pkg::MODE_RESET;
      else if (pick < 28) m = tst_pkg::MODE_SET;
      else if (pick < 53) m = tst_pkg::MODE_CLEAR;
      else if (pick < 76) m = tst_pkg::MODE_NEXT;
      else if (pick < 97) m = tst_pkg::MODE_PREV;
      else m = $urandom_range(tst_pkg::MODE_PREV + 1, (1 << tst_pkg::MODE_W) - 1);
      pick = $urandom_range(0, 9);
      if (pick < 8) c = $urandom_range(0, n - 1);
      else if (pick == 8) c = $urandom_range(n, tst_pkg::MAX_COLUMNS);
      else c = $urandom_range(0, (1 << tst_pkg::COL_W) - 1);
      send_command(m[tst_pkg::MODE_W-1:0], c[tst_pkg::COL_W-1:0]);
      if (m <= tst_pkg::MODE_PREV) done++;
    end
  endtask

  initial begin
    tbl         = new();
    src_idle    = 1'b1;
    snk_idle    = 1'b1;
    hold_cycles = 0;
    rst         = 1'b1;
    s_tvalid    = 1'b0;
    s_tdata     = '0;
    cfg_valid   = 1'b0;
    cfg_data    = '0;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed: power-on pattern at 80 columns, edges, ignored writes and codes
    write_column_count(tst_pkg::COUNT_W'(tst_pkg::COUNT_RESET));
    send_command(tst_pkg::MODE_NEXT, 9'd0);
    send_command(tst_pkg::MODE_NEXT, 9'd79);
    send_command(tst_pkg::MODE_NEXT, 9'd511);
    send_command(tst_pkg::MODE_PREV, 9'd0);
    send_command(tst_pkg::MODE_PREV, 9'd1);
    send_command(tst_pkg::MODE_PREV, 9'd256);
    send_command(tst_pkg::MODE_PREV, 9'd9);
    send_command(tst_pkg::MODE_SET, 9'd79);
    send_command(tst_pkg::MODE_NEXT, 9'd72);
    send_command(tst_pkg::MODE_SET, 9'd80);
    send_command(tst_pkg::MODE_NEXT, 9'd79);
    send_command(tst_pkg::MODE_CLEAR, 9'd0);
    send_command(tst_pkg::MODE_PREV, 9'd8);
    send_command(tst_pkg::MODE_CLEAR, 9'd8);
    send_command(tst_pkg::MODE_NEXT, 9'd0);
    send_command(tst_pkg::MODE_SET, 9'd0);
    for (int k = tst_pkg::MODE_PREV + 1; k < (1 << tst_pkg::MODE_W); k++)
      send_command(k[tst_pkg::MODE_W-1:0], 9'd3);
    send_command(tst_pkg::MODE_SET, 9'd511);
    send_command(tst_pkg::MODE_RESET, 9'd0);
    send_command(tst_pkg::MODE_PREV, 9'd80);
    send_command(tst_pkg::MODE_NEXT, 9'd78);
    send_command(tst_pkg::MODE_PREV, 9'd511);
    send_command(tst_pkg::MODE_CLEAR, 9'd72);
    send_command(tst_pkg::MODE_PREV, 9'd79);

    // Random phases over the count extremes, varying idling on each side
    run_phase(tst_pkg::MAX_COLUMNS, PHASE_ITEMS, 1'b1);
    src_idle    = 1'b0;
    hold_cycles = LONG_HOLD;
    run_phase(1, PHASE_ITEMS, 1'b1);
    src_idle = 1'b1;
    snk_idle = 1'b0;
    run_phase(0, PHASE_ITEMS, 1'b1);
    snk_idle = 1'b1;
    run_phase((1 << tst_pkg::COUNT_W) - 1, PHASE_ITEMS, 1'b0);
    src_idle = 1'b0;
    snk_idle = 1'b0;
    run_phase(tst_pkg::TAB_SPACING, PHASE_ITEMS, 1'b1);
    src_idle = 1'b1;
    snk_idle = 1'b1;
    run_phase(tst_pkg::COUNT_RESET, PHASE_ITEMS, 1'b1);
    run_phase($urandom_range(1, tst_pkg::MAX_COLUMNS), PHASE_ITEMS, 1'b1);
    run_phase($urandom_range(0, (1 << tst_pkg::COUNT_W) - 1), PHASE_ITEMS, 1'b0);

    settle();
    if (tbl.mismatches == 0 && tbl.expected_cols.size() == 0) begin
      $display("** tab_stop_table_core: PASSED **");
    end else begin
      $display("** tab_stop_table_core: FAILED **");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
hdl/tst_pkg.sv
hdl/tab_stop_table_core.sv
sim/testbench.sv
